// ===== src/vzz_pkg.sv =====
package vzz_pkg;

  localparam int unsigned ValueW = 64;

  localparam logic [6:0] GroupMask = 7'h7F;
  localparam int unsigned ContBit = 7;
  localparam logic [3:0] LastGroup = 4'd9;
  localparam logic [6:0] GroupBits = 7'd7;

  // one decoded result, zigzag not yet applied
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              error;
  } result_t;

  function automatic logic [ValueW-1:0] zigzag_decode(input logic [ValueW-1:0] v);
    zigzag_decode = (v >> 1) ^ {ValueW{v[0]}};
  endfunction

endpackage

// ===== src/vzz_front.sv =====
module vzz_front
  import vzz_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       buffer_end_i,
  input  logic       new_buffer_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output result_t    q_entry_o
);

  logic [ValueW-1:0] acc_q, acc_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              failed_q, failed_d;

  logic [ValueW-1:0] acc_base, acc_new;
  logic [3:0]        cnt_base;
  logic              fail_base;
  logic              accept;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  always_comb begin
    acc_base  = new_buffer_i ? '0 : acc_q;
    cnt_base  = new_buffer_i ? '0 : cnt_q;
    fail_base = new_buffer_i ? 1'b0 : failed_q;
    if (cnt_base > LastGroup) begin
      cnt_base = '0;
    end
    acc_new = acc_base |
              ({{(ValueW-7){1'b0}}, data_byte_i[6:0] & GroupMask} << (7'(cnt_base) * GroupBits));

    acc_d           = acc_q;
    cnt_d           = cnt_q;
    failed_d        = failed_q;
    q_push_o        = 1'b0;
    q_entry_o.value = acc_new;
    q_entry_o.error = 1'b0;

    if (accept) begin
      acc_d    = acc_base;
      cnt_d    = cnt_base;
      failed_d = fail_base;
      if (!fail_base) begin
        if (cnt_base == LastGroup && data_byte_i > 8'd1) begin
          // overflow on the tenth byte
          failed_d        = 1'b1;
          acc_d           = '0;
          cnt_d           = '0;
          q_push_o        = 1'b1;
          q_entry_o.value = '0;
          q_entry_o.error = 1'b1;
        end else if (!data_byte_i[ContBit]) begin
          acc_d    = '0;
          cnt_d    = '0;
          q_push_o = 1'b1;
        end else if (buffer_end_i) begin
          // truncation: continuation byte at buffer end
          failed_d        = 1'b1;
          acc_d           = '0;
          cnt_d           = '0;
          q_push_o        = 1'b1;
          q_entry_o.value = '0;
          q_entry_o.error = 1'b1;
        end else begin
          acc_d = acc_new;
          cnt_d = cnt_base + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ===== src/vzz_fifo.sv =====
module vzz_fifo
  import vzz_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t entry_i,
  output logic    full_o,
  input  logic    pop_i,
  output result_t entry_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/vzz_back.sv =====
module vzz_back
  import vzz_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              signed_mode_i,
  input  result_t           q_entry_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [ValueW-1:0] value_bits_o,
  output logic              error_o
);

  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_error_q;

  // refill the output stage when it is free or being drained
  assign q_pop_o      = !q_empty_i && (!out_valid_q || pop);
  assign empty        = !out_valid_q;
  assign value_bits_o = out_value_q;
  assign error_o      = out_error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_value_q <= signed_mode_i ? zigzag_decode(q_entry_i.value) : q_entry_i.value;
      out_error_q <= q_entry_i.error;
    end
  end

endmodule

// ===== src/varint_zigzag_decoder.sv =====
// Channel  Handshake                 Payload
// input    push / full               data_byte_i, buffer_end_i, new_buffer_i
// result   empty / pop               value_bits_o, error_o
// config   cfg_valid_i / cfg_ready_o cfg_data_i (signed_mode, bit 0)
//
// One byte per cycle while full is low: the accumulator update is a single shift-or per byte.
// The edge that accepts the last byte writes the front queue; the output register loads
// from the queue when it is empty or being popped, so pop can stall the result there.
// Throughput is one transaction a cycle while full is low.
// Reset clears accumulator, group count, failure flag, signed_mode and queues.
// full rises only when the FIFO_DEPTH-entry queue is full behind a stalled pop.
module varint_zigzag_decoder
  import vzz_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte_i,
  input  logic              buffer_end_i,
  input  logic              new_buffer_i,
  output logic              empty,
  input  logic              pop,
  output logic [ValueW-1:0] value_bits_o,
  output logic              error_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic    signed_mode_q;
  logic    q_push, q_full, q_pop, q_empty;
  result_t q_wr_entry, q_rd_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      signed_mode_q <= cfg_data_i;
    end
  end

  vzz_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .new_buffer_i (new_buffer_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_wr_entry)
  );

  vzz_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  vzz_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode_q),
    .q_entry_i     (q_rd_entry),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .value_bits_o  (value_bits_o),
    .error_o       (error_o)
  );

endmodule

// ===== bench/vzz_checker.sv =====
`timescale 1ns / 1ps

module vzz_checker
  import vzz_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  logic [7:0]        data_byte_i,
  input  logic              buffer_end_i,
  input  logic              new_buffer_i,
  input  logic              empty,
  input  logic              pop,
  input  logic [ValueW-1:0] value_bits_o,
  input  logic              error_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic              cfg_data_i,
  output int                mismatch_count_o,
  output int                outstanding_o
);

  result_t           pending_results[$];
  result_t           oldest;
  logic [ValueW-1:0] acc_q;
  logic [3:0]        groups_q;
  logic              failed_q;
  logic              signed_q;
  int                mismatches;

  task automatic push_error();
    result_t r;
    failed_q = 1'b1;
    acc_q    = '0;
    groups_q = '0;
    r.value  = '0;
    r.error  = 1'b1;
    pending_results.push_back(r);
  endtask

  // Advances the decoder state by one accepted byte and queues what it yields.
  task automatic decode_byte(input logic [7:0] b, input logic last, input logic fresh);
    result_t           r;
    logic [ValueW-1:0] v;
    if (fresh) begin
      failed_q = 1'b0;
      acc_q    = '0;
      groups_q = '0;
    end
    if (failed_q) return;
    if (groups_q > LastGroup) groups_q = '0;
    if (groups_q == LastGroup && b > 8'd1) begin
      push_error();
      return;
    end
    acc_q = acc_q | (ValueW'(b[6:0]) << (7 * int'(groups_q)));
    if (!b[ContBit]) begin
      v = acc_q;
      // zigzag: halve, then invert all bits when the low bit was set
      if (signed_q) v = (acc_q >> 1) ^ (-ValueW'(acc_q[0]));
      acc_q    = '0;
      groups_q = '0;
      r.value  = v;
      r.error  = 1'b0;
      pending_results.push_back(r);
    end else if (last) begin
      push_error();
    end else begin
      groups_q = groups_q + 4'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_results.delete();
      acc_q      = '0;
      groups_q   = '0;
      failed_q   = 1'b0;
      signed_q   = 1'b0;
      mismatches = 0;
    end else begin
      // result side first: a result never comes from a byte of the same edge
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: value %h error %b",
                   $time, value_bits_o, error_o);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          if (oldest.value !== value_bits_o || oldest.error !== error_o) begin
            $display("%0t: expected value %h error %b, actual value %h error %b",
                     $time, oldest.value, oldest.error, value_bits_o, error_o);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) signed_q = cfg_data_i;
      if (push && !full) decode_byte(data_byte_i, buffer_end_i, new_buffer_i);
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= pending_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vzz_pkg::*;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              push         = 1'b0;
  logic              full;
  logic [7:0]        data_byte_i  = 8'h00;
  logic              buffer_end_i = 1'b0;
  logic              new_buffer_i = 1'b0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [ValueW-1:0] value_bits_o;
  logic              error_o;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_data_i   = 1'b0;

  int mismatch_count;
  int outstanding;
  int send_idle  = 0;
  int recv_stall = 0;
  int hold_left  = 0;
  int sent_bytes = 0;

  varint_zigzag_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .new_buffer_i (new_buffer_i),
    .empty        (empty),
    .pop          (pop),
    .value_bits_o (value_bits_o),
    .error_o      (error_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  vzz_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .buffer_end_i     (buffer_end_i),
    .new_buffer_i     (new_buffer_i),
    .empty            (empty),
    .pop              (pop),
    .value_bits_o     (value_bits_o),
    .error_o          (error_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  // Offers one byte; returns at the edge that accepted it, push still high.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic fresh);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    data_byte_i  <= b;
    buffer_end_i <= last;
    new_buffer_i <= fresh;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_signed_mode(input logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One buffer of well-formed varints; now and then broken or noisy.
  task automatic send_buffer();
    logic [7:0] seq[$];
    int         nvals;
    int         len;
    int         flaw;
    logic       fresh;
    logic       last;
    nvals = $urandom_range(1, 4);
    for (int v = 0; v < nvals; v++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        if (i < len - 1) seq.push_back({1'b1, 7'($urandom)});
        else if (len == 10) seq.push_back(8'($urandom_range(0, 1)));
        else seq.push_back({1'b0, 7'($urandom)});
      end
    end
    flaw = $urandom_range(0, 11);
    case (flaw)
      0: begin
        // tenth byte too large
        for (int i = 0; i < 9; i++) seq.push_back({1'b1, 7'($urandom)});
        seq.push_back(8'($urandom_range(2, 255)));
      end
      1: seq.push_back({1'b1, 7'($urandom)});
      2: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom);
      default: ;
    endcase
    for (int i = 0; i < seq.size(); i++) begin
      fresh = (i == 0) ? (flaw != 4) : (flaw == 3 && $urandom_range(0, 7) == 0);
      last  = (i == seq.size() - 1) || (flaw == 3 && $urandom_range(0, 7) == 0);
      send_byte(seq[i], last, fresh);
    end
  endtask

  initial begin
    int phase_items;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_signed_mode(1'b0);

    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);  // continues past the buffer end
    for (int i = 0; i < 9; i++) send_byte(8'hFF, 1'b0, i == 0);
    send_byte(8'h01, 1'b1, 1'b0);  // all 64 bits set
    send_byte(8'hC5, 1'b1, 1'b1);  // truncated
    send_byte(8'h05, 1'b0, 1'b0);  // dropped, buffer failed
    for (int i = 0; i < 9; i++) send_byte(8'hFF, 1'b0, i == 0);
    send_byte(8'hFE, 1'b1, 1'b0);  // overflow and truncation at once
    send_byte(8'h2A, 1'b1, 1'b1);
    wait_drained();

    // back-pressure: hold the result side while single-byte values pile up
    write_signed_mode(1'b1);
    hold_left = 300;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 127)), 1'b1, 1'b1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_signed_mode(1'((p % 2) ^ (p / 4)));
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 45; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 45; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      phase_items = sent_bytes + 135;
      while (sent_bytes < phase_items) send_buffer();
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/vzz_pkg.sv
src/vzz_front.sv
src/vzz_fifo.sv
src/vzz_back.sv
src/varint_zigzag_decoder.sv
bench/vzz_checker.sv
bench/testbench.sv
